[hw/rtl/typed_task_dispatcher_lifo_core_defines.svh]
// Assertion macros shared by the task dispatcher RTL.
`ifndef TYPED_TASK_DISPATCHER_LIFO_CORE_DEFINES_SVH
`define TYPED_TASK_DISPATCHER_LIFO_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TTDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TTDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ttdl_pkg.sv]
// Types and constants of the typed task dispatcher with LIFO backlog.
`timescale 1ns / 1ps

package ttdl_pkg;

   localparam int ID_WIDTH          = 10;
   localparam int DELAY_WIDTH       = 4;
   localparam int KIND_WIDTH        = 2;
   localparam int COUNT_WIDTH       = 7;
   localparam int NUM_PROC          = 3;
   localparam int STACK_DEPTH_DFLT  = 64;

   localparam logic [KIND_WIDTH-1:0] KIND_NONE = 2'd0;

   typedef struct packed {
      logic                   task_valid;
      logic [ID_WIDTH-1:0]    task_id;
      logic [KIND_WIDTH-1:0]  task_kind;
      logic [DELAY_WIDTH-1:0] task_delay;
   } req_type;

   typedef struct packed {
      logic                   done_a;
      logic [ID_WIDTH-1:0]    done_id_a;
      logic                   done_b;
      logic [ID_WIDTH-1:0]    done_id_b;
      logic                   done_c;
      logic [ID_WIDTH-1:0]    done_id_c;
      logic                   overflow;
      logic [COUNT_WIDTH-1:0] waiting_count;
      logic [NUM_PROC-1:0]    busy_mask;
   } rsp_type;

   // One backlog entry as held in the stack.
   typedef struct packed {
      logic [ID_WIDTH-1:0]    id;
      logic [KIND_WIDTH-1:0]  kind;
      logic [DELAY_WIDTH-1:0] delay;
   } entry_type;

endpackage

[hw/rtl/typed_task_dispatcher_lifo_core.sv]
// Typed task dispatcher: three processors and a LIFO backlog in a top register and one memory.
`timescale 1ns / 1ps

// One tick per transfer: assert start with req_data, and the tick is taken at
// the rising edge where busy is low. busy never rises, so a tick can be taken
// in every cycle. The result of a tick appears on rsp_data in the next cycle,
// marked by rsp_strobe for that single cycle; the receiver cannot stall
// it and must capture it then. A tick with task_valid low still advances the
// processors and the backlog and still gives a result. The stack top lives in
// a register; the entries below it sit in a single-port-read, single-port-write
// synchronous memory. After a pop the next top is read from the memory and is
// used straight from the read register in the following tick, so the registered
// memory read never stalls a tick. Stack entries need no reset and no
// clearing pass: only entries that were pushed are ever read.
module typed_task_dispatcher_lifo_core #(
   parameter int STACK_DEPTH = ttdl_pkg::STACK_DEPTH_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ttdl_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ttdl_pkg::rsp_type rsp_data
);

`include "typed_task_dispatcher_lifo_core_defines.svh"

   localparam int LW = $clog2(STACK_DEPTH + 1);   // level counter, holds the depth itself
   localparam int AW = $clog2(STACK_DEPTH);       // memory address
   localparam int IW = ttdl_pkg::ID_WIDTH;
   localparam int DW = ttdl_pkg::DELAY_WIDTH;
   localparam int KW = ttdl_pkg::KIND_WIDTH;
   localparam int NP = ttdl_pkg::NUM_PROC;
   localparam int CW = ttdl_pkg::COUNT_WIDTH;

   // Processor state
   logic [NP-1:0]          pbusy_ff, pbusy_in;
   logic [IW-1:0]          pid_ff    [NP];
   logic [IW-1:0]          pid_in    [NP];
   logic [DW-1:0]          pcnt_ff   [NP];
   logic [DW-1:0]          pcnt_in   [NP];

   // Backlog: top in a register, the rest in memory
   ttdl_pkg::entry_type    stack_mem [STACK_DEPTH];
   ttdl_pkg::entry_type    top_ff, top_in;
   ttdl_pkg::entry_type    rd_ff;
   logic                   refill_ff, refill_in;
   logic [LW-1:0]          level_ff, level_in;

   // Result register
   logic                   rsp_strobe_ff;
   ttdl_pkg::rsp_type      rsp_ff, rsp_in;

   // Tick datapath
   logic                   accept;
   logic                   arrive;
   logic                   hit_busy;
   logic                   push, pop, overflow_c;
   ttdl_pkg::entry_type    new_entry, top_cur, top_sel;
   logic [LW-1:0]          level_push;
   logic [LW-1:0]          level_m1, level_m2;
   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [NP-1:0]          done_c;
   logic [IW-1:0]          done_id_c [NP];
   logic [LW+CW-1:0]       level_ext;

   assign busy       = 1'b0;
   assign accept     = start & ~busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign arrive     = req_data.task_valid && (req_data.task_kind != ttdl_pkg::KIND_NONE);
   assign new_entry  = '{id: req_data.task_id, kind: req_data.task_kind,
                         delay: req_data.task_delay};

   // The current top comes straight from the read register right after a pop.
   assign top_cur    = refill_ff ? rd_ff : top_ff;

   assign level_m1   = level_ff - LW'(1);
   assign level_m2   = level_ff - LW'(2);
   assign wr_addr    = level_m1[AW-1:0];
   assign rd_addr    = level_m2[AW-1:0];

   always_comb begin
      pbusy_in   = pbusy_ff;
      pid_in     = pid_ff;
      pcnt_in    = pcnt_ff;
      done_c     = '0;
      push       = 1'b0;
      pop        = 1'b0;
      overflow_c = 1'b0;
      hit_busy   = 1'b0;
      for (int p = 0; p < NP; p++) begin
         done_id_c[p] = '0;
      end

      // Arrival: claim the idle processor of this kind, else push or drop.
      for (int p = 0; p < NP; p++) begin
         if (req_data.task_kind == KW'(p + 1)) begin
            hit_busy = pbusy_ff[p];
         end
      end
      if (accept && arrive) begin
         if (!hit_busy) begin
            for (int p = 0; p < NP; p++) begin
               if (req_data.task_kind == KW'(p + 1)) begin
                  pbusy_in[p] = 1'b1;
                  pid_in[p]   = req_data.task_id;
                  pcnt_in[p]  = req_data.task_delay;
               end
            end
         end else if (level_ff != LW'(STACK_DEPTH)) begin
            push = 1'b1;
         end else begin
            overflow_c = 1'b1;
         end
      end

      // Work: count down, or complete and release the processor.
      if (accept) begin
         for (int p = 0; p < NP; p++) begin
            if (pbusy_in[p]) begin
               if (pcnt_in[p] != '0) begin
                  pcnt_in[p] = pcnt_in[p] - DW'(1);
               end else begin
                  pbusy_in[p]  = 1'b0;
                  done_c[p]    = 1'b1;
                  done_id_c[p] = pid_in[p];
                  pid_in[p]    = '0;
               end
            end
         end
      end

      // Stack top check: pop only if the top's processor is now idle.
      top_sel    = push ? new_entry : top_cur;
      level_push = push ? level_ff + LW'(1) : level_ff;
      if (accept && level_push != '0) begin
         for (int p = 0; p < NP; p++) begin
            if (top_sel.kind == KW'(p + 1) && !pbusy_in[p]) begin
               pbusy_in[p] = 1'b1;
               pid_in[p]   = top_sel.id;
               pcnt_in[p]  = top_sel.delay;
               pop         = 1'b1;
            end
         end
      end
      level_in = pop ? level_push - LW'(1) : level_push;

      // Push without pop spills the old top to memory; pop without push
      // fetches the entry below it.
      top_in    = (push && !pop) ? new_entry : top_cur;
      wr_en     = push && !pop && (level_ff != '0);
      rd_en     = pop && !push && (level_ff >= LW'(2));
      refill_in = rd_en;
   end

   assign level_ext = {{CW{1'b0}}, level_in};

   always_comb begin
      rsp_in               = '0;
      rsp_in.done_a        = done_c[0];
      rsp_in.done_id_a     = done_id_c[0];
      rsp_in.done_b        = done_c[1];
      rsp_in.done_id_b     = done_id_c[1];
      rsp_in.done_c        = done_c[2];
      rsp_in.done_id_c     = done_id_c[2];
      rsp_in.overflow      = overflow_c;
      rsp_in.waiting_count = level_ext[CW-1:0];
      rsp_in.busy_mask     = pbusy_in;
   end

   // Backlog memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= top_cur;
      end
      if (rd_en) begin
         rd_ff <= stack_mem[rd_addr];
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pbusy_ff      <= '0;
         level_ff      <= '0;
         refill_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int p = 0; p < NP; p++) begin
            pid_ff[p]  <= '0;
            pcnt_ff[p] <= '0;
         end
      end else begin
         pbusy_ff      <= pbusy_in;
         level_ff      <= level_in;
         refill_ff     <= refill_in;
         rsp_strobe_ff <= accept;
         pid_ff        <= pid_in;
         pcnt_ff       <= pcnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   `TTDL_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, level_ff <= LW'(STACK_DEPTH), "stack level beyond depth")
   `TTDL_ASSERT_NOW(a_refill_nonempty, clock, reset, refill_ff, level_ff != '0, "refill with empty stack")
   `TTDL_ASSERT_NOW(a_overflow_full, clock, reset, overflow_c, (level_ff == LW'(STACK_DEPTH)) && !push, "drop while stack not full")
   `TTDL_ASSERT_NEXT(a_strobe_on_tick, clock, reset, accept, rsp_strobe, "no result after tick")
   `TTDL_ASSERT_NEXT(a_no_strobe_idle, clock, reset, !accept, !rsp_strobe, "result without tick")

endmodule

[test/typed_task_dispatcher_lifo_checker.sv]
// Checker for the task dispatcher: predicts each tick's result and compares it.
`timescale 1ns / 1ps

module typed_task_dispatcher_lifo_checker #(
   parameter int STACK_DEPTH = ttdl_pkg::STACK_DEPTH_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ttdl_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  ttdl_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count,
   output logic              model_idle,
   output int                tick_count,
   output int                done_count,
   output int                overflow_count
);

   localparam int NP = ttdl_pkg::NUM_PROC;
   localparam int IW = ttdl_pkg::ID_WIDTH;
   localparam int DW = ttdl_pkg::DELAY_WIDTH;
   localparam int CW = ttdl_pkg::COUNT_WIDTH;

   // Model state: three processors and the backlog stack.
   logic                proc_on   [NP];
   logic [IW-1:0]       proc_tag  [NP];
   logic [DW-1:0]       proc_left [NP];
   ttdl_pkg::entry_type backlog   [STACK_DEPTH];
   int                  backlog_level;

   ttdl_pkg::rsp_type expected_q [$];
   int                errors;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic launch_task(input int k, input logic [IW-1:0] id,
                              input logic [DW-1:0] delay);
      proc_on[k]   = 1'b1;
      proc_tag[k]  = id;
      proc_left[k] = delay;
   endtask

   // Run one tick: arrival, then countdown or completion, then the stack-top check.
   task automatic dispatch_tick(input ttdl_pkg::req_type r, output ttdl_pkg::rsp_type o);
      int                  k;
      logic                fin     [NP];
      logic [IW-1:0]       fin_tag [NP];
      ttdl_pkg::entry_type top;
      o = '0;
      for (k = 0; k < NP; k++) begin
         fin[k]     = 1'b0;
         fin_tag[k] = '0;
      end
      if (r.task_valid && r.task_kind != ttdl_pkg::KIND_NONE) begin
         k = int'(r.task_kind) - 1;
         if (!proc_on[k]) begin
            launch_task(k, r.task_id, r.task_delay);
         end else if (backlog_level < STACK_DEPTH) begin
            backlog[backlog_level] = '{id: r.task_id, kind: r.task_kind, delay: r.task_delay};
            backlog_level++;
         end else begin
            o.overflow = 1'b1;
         end
      end
      for (k = 0; k < NP; k++) begin
         if (proc_on[k]) begin
            if (proc_left[k] != 0) begin
               proc_left[k]--;
            end else begin
               proc_on[k]  = 1'b0;
               fin[k]      = 1'b1;
               fin_tag[k]  = proc_tag[k];
               proc_tag[k] = '0;
            end
         end
      end
      if (backlog_level > 0) begin
         top = backlog[backlog_level-1];
         if (top.kind != ttdl_pkg::KIND_NONE) begin
            k = int'(top.kind) - 1;
            if (!proc_on[k]) begin
               launch_task(k, top.id, top.delay);
               backlog_level--;
            end
         end
      end
      o.done_a        = fin[0];
      o.done_id_a     = fin_tag[0];
      o.done_b        = fin[1];
      o.done_id_b     = fin_tag[1];
      o.done_c        = fin[2];
      o.done_id_c     = fin_tag[2];
      o.waiting_count = CW'(backlog_level);
      for (k = 0; k < NP; k++)
         o.busy_mask[k] = proc_on[k];
   endtask

   always @(posedge clock) begin
      ttdl_pkg::rsp_type want;
      ttdl_pkg::rsp_type got;
      int                k;
      if (reset) begin
         for (k = 0; k < NP; k++) begin
            proc_on[k]   = 1'b0;
            proc_tag[k]  = '0;
            proc_left[k] = '0;
         end
         backlog_level = 0;
         expected_q.delete();
      end else begin
         if (rsp_strobe) begin
            got = rsp_data;
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(got), 32'd0);
            end else begin
               want = expected_q.pop_front();
               if (got.done_a !== want.done_a)
                  report_mismatch("done_a", 32'(got.done_a), 32'(want.done_a));
               if (got.done_id_a !== want.done_id_a)
                  report_mismatch("done_id_a", 32'(got.done_id_a), 32'(want.done_id_a));
               if (got.done_b !== want.done_b)
                  report_mismatch("done_b", 32'(got.done_b), 32'(want.done_b));
               if (got.done_id_b !== want.done_id_b)
                  report_mismatch("done_id_b", 32'(got.done_id_b), 32'(want.done_id_b));
               if (got.done_c !== want.done_c)
                  report_mismatch("done_c", 32'(got.done_c), 32'(want.done_c));
               if (got.done_id_c !== want.done_id_c)
                  report_mismatch("done_id_c", 32'(got.done_id_c), 32'(want.done_id_c));
               if (got.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
               if (got.waiting_count !== want.waiting_count)
                  report_mismatch("waiting_count", 32'(got.waiting_count),
                                  32'(want.waiting_count));
               if (got.busy_mask !== want.busy_mask)
                  report_mismatch("busy_mask", 32'(got.busy_mask), 32'(want.busy_mask));
            end
         end
         if (start && !busy) begin
            dispatch_tick(req_data, want);
            expected_q.push_back(want);
            tick_count     <= tick_count + 1;
            done_count     <= done_count + int'(want.done_a) + int'(want.done_b)
                              + int'(want.done_c);
            overflow_count <= overflow_count + int'(want.overflow);
         end
      end
      pending_count <= expected_q.size();
      model_idle    <= (backlog_level == 0) && !proc_on[0] && !proc_on[1] && !proc_on[2];
      error_count   <= errors;
   end

endmodule

[test/typed_task_dispatcher_lifo_core_tb.sv]
// Top of the task dispatcher testbench: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module typed_task_dispatcher_lifo_core_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ROUNDS      = 1;
   localparam int MIXED_TICKS = 70;
   localparam int FLOOD_TICKS = 85;
   localparam int TAIL_TICKS  = 40;
   localparam int DRAIN_CAP   = 1500;
   localparam int IDW         = ttdl_pkg::ID_WIDTH;
   localparam int DLW         = ttdl_pkg::DELAY_WIDTH;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   ttdl_pkg::req_type req_data  = '0;
   logic              busy;
   logic              rsp_strobe;
   ttdl_pkg::rsp_type rsp_data;

   int   error_count;
   int   pending_count;
   logic model_idle;
   int   tick_count;
   int   done_count;
   int   overflow_count;
   int   cycles = 0;

   // Idling control: gaps only come while idle_on is set.
   bit   idle_on = 1'b0;

   typed_task_dispatcher_lifo_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   typed_task_dispatcher_lifo_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .model_idle     (model_idle),
      .tick_count     (tick_count),
      .done_count     (done_count),
      .overflow_count (overflow_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Guard against a hung handshake or a result stream that never ends.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("typed_task_dispatcher_lifo_core_tb failed");
         $finish;
      end
   end

   // Offer one tick and hold it until the transfer happens. Drop start only when
   // a gap is inserted, so start is never lowered and raised in the same step.
   task automatic send_tick(input ttdl_pkg::req_type r);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   function automatic ttdl_pkg::req_type make_task(input bit valid, input logic [1:0] kind,
                                                   input int id, input int delay);
      ttdl_pkg::req_type r;
      r.task_valid = valid;
      r.task_kind  = kind;
      r.task_id    = IDW'(id);
      r.task_delay = DLW'(delay);
      return r;
   endfunction

   // Mostly real tasks of kinds 1 to 3 and mostly short delays; now and then
   // an empty tick, a kind-zero task or a long delay.
   function automatic ttdl_pkg::req_type mixed_task();
      bit          valid;
      logic [1:0]  kind;
      int          delay;
      valid = ($urandom_range(0, 9) < 7);
      kind  = ($urandom_range(0, 19) == 0) ? ttdl_pkg::KIND_NONE : 2'($urandom_range(1, 3));
      delay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
      return make_task(valid, kind, $urandom_range(0, 1023), delay);
   endfunction

   function automatic ttdl_pkg::req_type empty_tick();
      return make_task(1'b0, 2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                       $urandom_range(0, 15));
   endfunction

   initial begin
      logic [1:0] flood_kind;
      int         n;

      // Hold reset from the start, then release it at an edge.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every kind, zero-delay completion in the same
      // tick, kind zero ignored, fields of an empty tick ignored, and stacking
      // behind busy processors with a blocked top of a different kind.
      send_tick(make_task(1'b1, 2'd1, 0, 0));
      send_tick(make_task(1'b1, 2'd2, 1023, 15));
      send_tick(make_task(1'b1, 2'd3, 'h155, 15));
      send_tick(make_task(1'b1, 2'd2, 'h2AA, 3));
      send_tick(make_task(1'b1, 2'd1, 5, 0));
      send_tick(make_task(1'b1, ttdl_pkg::KIND_NONE, 1023, 15));
      send_tick(make_task(1'b0, 2'd3, 1023, 15));
      send_tick(make_task(1'b1, 2'd3, 1000, 1));
      send_tick(make_task(1'b1, 2'd1, 7, 2));
      send_tick(make_task(1'b1, 2'd1, 8, 0));
      send_tick(make_task(1'b1, 2'd1, 'h3F0, 15));
      send_tick(make_task(1'b1, 2'd3, 'h00F, 0));
      repeat (8) send_tick(make_task(1'b0, ttdl_pkg::KIND_NONE, 0, 0));

      // Random rounds: mixed traffic, a flood of one kind that fills the stack
      // and overflows it, then empty ticks until the backlog has drained.
      for (int round = 0; round < ROUNDS; round++) begin
         for (int i = 0; i < MIXED_TICKS; i++) begin
            if (i % 20 == 0)
               idle_on = $urandom_range(0, 2) != 0;
            send_tick(mixed_task());
         end
         flood_kind = 2'((round % 3) + 1);
         for (int i = 0; i < FLOOD_TICKS; i++)
            send_tick(make_task(1'b1, flood_kind, $urandom_range(0, 1023),
                                $urandom_range(0, 11)));
         n = 0;
         while (!model_idle && n < DRAIN_CAP) begin
            send_tick(empty_tick());
            n++;
         end
         // Pause once until every expected result has come.
         if (round == ROUNDS - 1) begin
            start <= 1'b0;
            while (pending_count != 0) @(posedge clock);
            @(posedge clock);
         end
      end

      // Last part: back-to-back ticks, no idling.
      idle_on = 1'b0;
      for (int i = 0; i < TAIL_TICKS; i++)
         send_tick(mixed_task());
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d ticks with %0d task completions and %0d stack overflow drops",
               tick_count, done_count, overflow_count);
      $display("including directed cases, a stack flood past full and a full drain");
      if (error_count == 0) begin
         $display("typed_task_dispatcher_lifo_core_tb passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("typed_task_dispatcher_lifo_core_tb failed");
      end
      $finish;
   end

endmodule
